>>> hdl/uclp_pkg.sv
// Shared types, constants and character tables for the command-line parser.
// No dependencies; used by every module of the block.
package uclp_pkg;

    localparam int DEF_MAX_NODES  = 8;
    localparam int DEF_LINE_LIMIT = 40;

    localparam int TGT_W      = 6;   // holds any explicit target below 64
    localparam int CNT_W      = 4;   // known-node count register
    localparam int MASK_W     = 8;   // node busy mask
    localparam int MASK_IDX_W = 3;
    localparam int CMP_W      = TGT_W + 1;

    localparam logic [CNT_W-1:0] KNOWN_NODES_RST = 4'd1;
    localparam logic [7:0]       CHAR_CR         = 8'h0D;
    localparam logic [7:0]       CHAR_LF         = 8'h0A;
    localparam int               PING_LEN        = 8;
    localparam int               MEAS_LEN        = 11;
    localparam int               MEAS_PFX_LEN    = 12;

    typedef enum logic [1:0] {
        K_PING     = 2'd0,
        K_MEAS     = 2'd1,
        K_MEAS_TGT = 2'd2,
        K_UNKNOWN  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RPL_PING    = 2'd0,
        RPL_QUEUED  = 2'd1,
        RPL_BUSY    = 2'd2,
        RPL_UNKNOWN = 2'd3
    } t_reply;

    // One completed line as handed from the front to the back
    typedef struct packed {
        t_kind              kind;
        logic [TGT_W-1:0]   target;
        logic               watchdog_tripped;
        logic               app_ready;
        logic [MASK_W-1:0]  node_busy_mask;
    } t_cmd;

    function automatic logic [7:0] ping_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h43; // C
            3'd1:    c = 8'h4D; // M
            3'd2:    c = 8'h44; // D
            3'd3:    c = 8'h3A; // :
            3'd4:    c = 8'h50; // P
            3'd5:    c = 8'h49; // I
            3'd6:    c = 8'h4E; // N
            3'd7:    c = 8'h47; // G
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] meas_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h4D; // M
            4'd2:    c = 8'h44; // D
            4'd3:    c = 8'h3A; // :
            4'd4:    c = 8'h4D; // M
            4'd5:    c = 8'h45; // E
            4'd6:    c = 8'h41; // A
            4'd7:    c = 8'h53; // S
            4'd8:    c = 8'h55; // U
            4'd9:    c = 8'h52; // R
            4'd10:   c = 8'h45; // E
            4'd11:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/uclp_front.sv
// Front end: accepts items, tracks the line being received and classifies
// completed lines into commands. Depends on uclp_pkg.
module uclp_front #(
    parameter int MAX_NODES  = uclp_pkg::DEF_MAX_NODES,
    parameter int LINE_LIMIT = uclp_pkg::DEF_LINE_LIMIT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_watchdog_tripped,
    input  logic                          i_app_ready,
    input  logic [uclp_pkg::MASK_W-1:0]   i_node_busy_mask,
    input  logic                          i_full,
    output logic                          o_push,
    output uclp_pkg::t_cmd                o_cmd
);

    localparam int LW    = $clog2(LINE_LIMIT);
    localparam int VAL_W = $clog2(MAX_NODES + 2);
    localparam int PRD_W = VAL_W + 4;

    logic [LW-1:0]    r_line_length, n_line_length;
    logic             r_ping_cand,   n_ping_cand;
    logic [VAL_W-1:0] r_node_value,  n_node_value;
    logic             r_num_inv,     n_num_inv;
    logic             r_line_inv,    n_line_inv;

    logic             accept;
    logic             is_term;
    logic [PRD_W-1:0] prod;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign is_term = (i_rx_byte == uclp_pkg::CHAR_CR) || (i_rx_byte == uclp_pkg::CHAR_LF);
    assign prod    = PRD_W'(r_node_value) * PRD_W'(10) + PRD_W'(i_rx_byte[3:0]);

    always_comb begin
        n_line_length = r_line_length;
        n_ping_cand   = r_ping_cand;
        n_node_value  = r_node_value;
        n_num_inv     = r_num_inv;
        n_line_inv    = r_line_inv;
        o_push        = 1'b0;

        o_cmd.kind             = uclp_pkg::K_UNKNOWN;
        o_cmd.target           = uclp_pkg::TGT_W'(r_node_value);
        o_cmd.watchdog_tripped = i_watchdog_tripped;
        o_cmd.app_ready        = i_app_ready;
        o_cmd.node_busy_mask   = i_node_busy_mask;

        if (r_ping_cand && r_line_length == LW'(uclp_pkg::PING_LEN)) begin
            o_cmd.kind = uclp_pkg::K_PING;
        end else if (!r_line_inv && r_line_length == LW'(uclp_pkg::MEAS_LEN)) begin
            o_cmd.kind = uclp_pkg::K_MEAS;
        end else if (!r_line_inv && r_line_length > LW'(uclp_pkg::MEAS_PFX_LEN) &&
                     !r_num_inv && r_node_value < VAL_W'(MAX_NODES)) begin
            o_cmd.kind = uclp_pkg::K_MEAS_TGT;
        end

        if (accept) begin
            if (i_op || is_term || r_line_length >= LW'(LINE_LIMIT - 1)) begin
                // error event, end of line or overlong line: start over
                o_push        = !i_op && is_term && (r_line_length != '0);
                n_line_length = '0;
                n_ping_cand   = 1'b1;
                n_node_value  = '0;
                n_num_inv     = 1'b0;
                n_line_inv    = 1'b0;
            end else begin
                if (r_line_length >= LW'(uclp_pkg::PING_LEN) ||
                    i_rx_byte != uclp_pkg::ping_char(r_line_length[2:0])) begin
                    n_ping_cand = 1'b0;
                end
                if (!r_line_inv) begin
                    if (r_line_length < LW'(uclp_pkg::MEAS_PFX_LEN)) begin
                        if (i_rx_byte != uclp_pkg::meas_char(r_line_length[3:0])) begin
                            n_line_inv = 1'b1;
                        end
                    end else if (!r_num_inv) begin
                        if (!(i_rx_byte inside {[8'h30:8'h39]}) ||
                            r_node_value > VAL_W'(MAX_NODES)) begin
                            n_num_inv = 1'b1;
                        end else if (prod > PRD_W'(MAX_NODES + 1)) begin
                            // saturate at MAX_NODES + 1, above every valid node
                            n_node_value = VAL_W'(MAX_NODES + 1);
                        end else begin
                            n_node_value = prod[VAL_W-1:0];
                        end
                    end
                end
                n_line_length = r_line_length + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= '0;
            r_ping_cand   <= 1'b1;
            r_node_value  <= '0;
            r_num_inv     <= 1'b0;
            r_line_inv    <= 1'b0;
        end else begin
            r_line_length <= n_line_length;
            r_ping_cand   <= n_ping_cand;
            r_node_value  <= n_node_value;
            r_num_inv     <= n_num_inv;
            r_line_inv    <= n_line_inv;
        end
    end

endmodule

>>> hdl/uclp_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on uclp_pkg for the command type.
module uclp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  uclp_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output uclp_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);

    uclp_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> hdl/uclp_back.sv
// Back end: holds the known-node count and the active node, checks busy conditions
// and produces the registered reply. Depends on uclp_pkg.
module uclp_back #(
    parameter int MAX_NODES = uclp_pkg::DEF_MAX_NODES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [uclp_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                       i_empty,
    input  uclp_pkg::t_cmd             i_cmd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_reply_code,
    output logic                       o_measure_request,
    output logic [2:0]                 o_measure_node
);

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    logic [uclp_pkg::CNT_W-1:0] r_known_nodes;
    logic [NODE_W-1:0]          r_active, n_active;
    logic                       r_valid;
    uclp_pkg::t_reply           r_reply, n_reply;
    logic                       r_req, n_req;
    logic [2:0]                 r_node, n_node;

    logic [NODE_W-1:0]          sel_node;
    logic [uclp_pkg::CMP_W-1:0] tgt_x, cnt_x, node_x;

    assign o_cfg_ready = 1'b1;
    assign o_pop       = !i_empty && (!r_valid || i_ready);

    assign tgt_x    = uclp_pkg::CMP_W'(i_cmd.target);
    assign cnt_x    = uclp_pkg::CMP_W'(r_known_nodes);
    assign sel_node = (i_cmd.kind == uclp_pkg::K_MEAS_TGT) ? i_cmd.target[NODE_W-1:0]
                                                           : r_active;
    assign node_x   = uclp_pkg::CMP_W'(sel_node);

    always_comb begin
        n_active = r_active;
        n_reply  = uclp_pkg::RPL_UNKNOWN;
        n_req    = 1'b0;
        n_node   = 3'd0;
        case (i_cmd.kind)
            uclp_pkg::K_PING: begin
                n_reply = uclp_pkg::RPL_PING;
            end
            uclp_pkg::K_MEAS, uclp_pkg::K_MEAS_TGT: begin
                if (i_cmd.watchdog_tripped || !i_cmd.app_ready) begin
                    n_reply = uclp_pkg::RPL_BUSY;
                end else if (i_cmd.kind == uclp_pkg::K_MEAS_TGT && tgt_x >= cnt_x) begin
                    n_reply = uclp_pkg::RPL_UNKNOWN;
                end else begin
                    // a valid explicit target sticks even if the node is busy
                    n_active = sel_node;
                    if (node_x >= cnt_x || node_x >= uclp_pkg::CMP_W'(uclp_pkg::MASK_W) ||
                        i_cmd.node_busy_mask[node_x[uclp_pkg::MASK_IDX_W-1:0]]) begin
                        n_reply = uclp_pkg::RPL_BUSY;
                    end else begin
                        n_reply = uclp_pkg::RPL_QUEUED;
                        n_req   = 1'b1;
                        n_node  = node_x[2:0];
                    end
                end
            end
            default: begin
                n_reply = uclp_pkg::RPL_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_reply <= n_reply;
            r_req   <= n_req;
            r_node  <= n_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known_nodes <= uclp_pkg::KNOWN_NODES_RST;
            r_active      <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_known_nodes <= i_cfg_data;
            end
            if (o_pop) begin
                r_active <= n_active;
                r_valid  <= 1'b1;
            end else if (i_ready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_reply_code      = r_reply;
    assign o_measure_request = r_req;
    assign o_measure_node    = r_node;

endmodule

>>> hdl/uart_command_line_parser.sv
// Command-line parser: one item per cycle while the reply queue has room; input stalls only when it is full.
// A terminator's reply passes the queue register and then the back-end output register before
// o_m_tvalid rises; back-pressure on the output can hold it in the queue.
// Bytes that end no line, error events and empty or overlong lines give no reply.
// Synchronous active-low reset clears the partial line and the queue, sets the
// active node to 0 and the known-node count to 1.
module uart_command_line_parser #(
    parameter int MAX_NODES  = uclp_pkg::DEF_MAX_NODES,
    parameter int LINE_LIMIT = uclp_pkg::DEF_LINE_LIMIT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [23:0]                i_s_tdata,  // rx_byte[7:0], watchdog_tripped[8],
                                                   // app_ready[9], node_busy_mask[17:10]
    input  logic                       i_s_tuser,  // op
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,  // reply_code[1:0], measure_request[2],
                                                   // measure_node[5:3]
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [uclp_pkg::CNT_W-1:0] i_cfg_data  // known_nodes
);

    uclp_pkg::t_cmd front_cmd;
    uclp_pkg::t_cmd queue_cmd;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    logic [1:0]     reply_code;
    logic           measure_request;
    logic [2:0]     measure_node;

    uclp_front #(
        .MAX_NODES  (MAX_NODES),
        .LINE_LIMIT (LINE_LIMIT)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_s_tvalid),
        .o_ready            (o_s_tready),
        .i_op               (i_s_tuser),
        .i_rx_byte          (i_s_tdata[7:0]),
        .i_watchdog_tripped (i_s_tdata[8]),
        .i_app_ready        (i_s_tdata[9]),
        .i_node_busy_mask   (i_s_tdata[17:10]),
        .i_full             (full),
        .o_push             (push),
        .o_cmd              (front_cmd)
    );

    uclp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    uclp_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_empty           (empty),
        .i_cmd             (queue_cmd),
        .o_pop             (pop),
        .o_valid           (o_m_tvalid),
        .i_ready           (i_m_tready),
        .o_reply_code      (reply_code),
        .o_measure_request (measure_request),
        .o_measure_node    (measure_node)
    );

    assign o_m_tdata = {2'b00, measure_node, measure_request, reply_code};

endmodule

>>> test/testbench.sv
// Self-checking testbench for uart_command_line_parser: random byte streams of command
// lines, errors and noise, with an item-level parser model predicting every reply.
// Depends on uclp_pkg and the parser RTL only.
module testbench;

    localparam int MAX_NODES   = uclp_pkg::DEF_MAX_NODES;
    localparam int LINE_LIMIT  = uclp_pkg::DEF_LINE_LIMIT;
    localparam int SETTLE_CYC  = 8;     // quiet margin after the last reply before a register write
    localparam int ITEMS_PHASE = 130;

    typedef enum logic [1:0] {
        ENT_ITEM,
        ENT_CFG,
        ENT_DRAIN
    } t_ent_kind;

    typedef struct {
        t_ent_kind  kind;
        logic       op;
        logic [7:0] ch;
        logic       wd;
        logic       ar;
        logic [7:0] mask;
        logic [3:0] cfg;
    } t_pend;

    typedef struct {
        uclp_pkg::t_reply code;
        logic             req;
        logic [2:0]       node;
    } t_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;    // rx_byte[7:0], watchdog_tripped[8], app_ready[9],
                                    // node_busy_mask[17:10]
    logic        i_s_tuser = 1'b0;  // op
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;         // reply_code[1:0], measure_request[2], measure_node[5:3]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data = '0;   // known_nodes

    // stimulus and expectations
    t_pend       pending_q[$];
    t_exp        reply_q[$];
    t_pend       cur_item;
    logic [7:0]  line_buf[$];
    int          stim_items = 0;
    bit          dir_on;
    logic        dir_wd, dir_ar;
    logic [7:0]  dir_mask;

    // parser model state
    int          line_len;
    bit          ping_hit;
    int          num_val;
    bit          num_bad;
    bit          line_bad;
    logic [2:0]  act_node;
    logic [3:0]  node_cnt;

    // pacing
    logic [15:0] cyc = '0;
    wire         calm = (cyc[7:6] == 2'b11);
    logic        quiet_tail = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          settle = 0;
    int          mismatches = 0;
    int          leftover = 0;

    string       ping_text = "CMD:PING";
    string       meas_text = "CMD:MEASURE:";

    uart_command_line_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void clear_line();
        line_len = 0;
        ping_hit = 1'b1;
        num_val  = 0;
        num_bad  = 1'b0;
        line_bad = 1'b0;
    endfunction

    function automatic t_exp serve_measure(input bit explicit_tgt, input int tgt,
                                           input t_pend it);
        t_exp r;
        r = '{uclp_pkg::RPL_BUSY, 1'b0, 3'd0};
        if (it.wd || !it.ar)
            return r;
        if (explicit_tgt) begin
            if (tgt >= int'(node_cnt)) begin
                r.code = uclp_pkg::RPL_UNKNOWN;
                return r;
            end
            // retarget sticks even if the node then turns out busy
            act_node = tgt[2:0];
        end
        if ({1'b0, act_node} >= node_cnt || it.mask[act_node])
            return r;
        r = '{uclp_pkg::RPL_QUEUED, 1'b1, act_node};
        return r;
    endfunction

    // one accepted item through the parser model
    task automatic advance_parser(input t_pend it);
        t_exp r;
        if (it.op) begin
            clear_line();
        end else if (it.ch == uclp_pkg::CHAR_CR || it.ch == uclp_pkg::CHAR_LF) begin
            if (line_len != 0) begin
                if (ping_hit && line_len == uclp_pkg::PING_LEN)
                    r = '{uclp_pkg::RPL_PING, 1'b0, 3'd0};
                else if (!line_bad && line_len == uclp_pkg::MEAS_LEN)
                    r = serve_measure(1'b0, 0, it);
                else if (!line_bad && line_len > uclp_pkg::MEAS_PFX_LEN && !num_bad &&
                         num_val < MAX_NODES)
                    r = serve_measure(1'b1, num_val, it);
                else
                    r = '{uclp_pkg::RPL_UNKNOWN, 1'b0, 3'd0};
                reply_q.push_back(r);
            end
            clear_line();
        end else if (line_len >= LINE_LIMIT - 1) begin
            // overlong line: drop it together with this byte
            clear_line();
        end else begin
            if (line_len >= uclp_pkg::PING_LEN || it.ch != ping_text[line_len])
                ping_hit = 1'b0;
            if (!line_bad) begin
                if (line_len < uclp_pkg::MEAS_PFX_LEN) begin
                    if (it.ch != meas_text[line_len])
                        line_bad = 1'b1;
                end else if (!num_bad) begin
                    if (it.ch < 8'h30 || it.ch > 8'h39 || num_val > MAX_NODES) begin
                        num_bad = 1'b1;
                    end else begin
                        num_val = num_val * 10 + int'(it.ch - 8'h30);
                        if (num_val > MAX_NODES + 1)
                            num_val = MAX_NODES + 1;
                    end
                end
            end
            line_len++;
        end
    endtask

    task automatic push_item(input logic op, input logic [7:0] ch);
        t_pend p;
        p.kind = ENT_ITEM;
        p.op   = op;
        p.ch   = ch;
        p.cfg  = '0;
        if (dir_on) begin
            p.wd   = dir_wd;
            p.ar   = dir_ar;
            p.mask = dir_mask;
        end else begin
            p.wd   = ($urandom_range(0, 9) == 0);
            p.ar   = ($urandom_range(0, 9) != 0);
            p.mask = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
        end
        pending_q.push_back(p);
        stim_items++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(1'b0, s[i]);
    endtask

    task automatic push_ctrl(input t_ent_kind kind, input logic [3:0] val);
        t_pend p;
        p = '{kind, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, val};
        pending_q.push_back(p);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // mostly well-formed command lines, some mutated, plus empty, garbage and long lines
    task automatic add_random_line();
        int sel;
        int len;
        int pos;
        int err_at;
        sel = $urandom_range(0, 99);
        err_at = -1;
        line_buf.delete();
        if (sel < 18) begin
            add_text("CMD:PING");
        end else if (sel < 36) begin
            add_text("CMD:MEASURE");
        end else if (sel < 66) begin
            add_text("CMD:MEASURE:");
            if ($urandom_range(0, 4) == 0)
                line_buf.push_back(8'h30);
            if ($urandom_range(0, 3) == 0)
                add_text($sformatf("%0d", $urandom_range(0, 999)));
            else
                add_text($sformatf("%0d", $urandom_range(0, 9)));
        end else if (sel < 74) begin
            // empty line
        end else if (sel < 82) begin
            len = $urandom_range(1, 12);
            repeat (len) line_buf.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 90) begin
            // around the line limit, zero padded so the target stays small
            len = $urandom_range(36, 44);
            add_text("CMD:MEASURE:");
            repeat (len - 13) line_buf.push_back(8'h30);
            line_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
        end else begin
            add_text("CMD:MEASURE:");
            if ($urandom_range(0, 1))
                line_buf.push_back(8'($urandom_range(0, 255)));
        end

        if (line_buf.size() != 0 && $urandom_range(0, 5) == 0) begin
            pos = $urandom_range(0, line_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: line_buf[pos] = 8'($urandom_range(0, 255));
                1: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
                default: err_at = pos;
            endcase
        end

        for (int i = 0; i < line_buf.size(); i++) begin
            if (i == err_at)
                push_item(1'b1, 8'($urandom_range(0, 255)));
            push_item(1'b0, line_buf[i]);
        end
        if ($urandom_range(0, 19) == 0)
            push_item(1'b1, 8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 19) != 0)
            push_item(1'b0, $urandom_range(0, 1) ? uclp_pkg::CHAR_CR : uclp_pkg::CHAR_LF);
    endtask

    // sender: items, register writes and drain pauses from pending_q
    always @(posedge i_clk) begin
        logic  s_busy;
        logic  c_busy;
        logic  nv_s;
        logic  nv_c;
        t_pend it;
        cyc <= cyc + 16'd1;
        quiet_tail <= (pending_q.size() < 100);
        if (!i_rst_n) begin
            i_s_tvalid  <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            s_busy = i_s_tvalid && !o_s_tready;
            c_busy = i_cfg_valid && !o_cfg_ready;
            if (i_s_tvalid && o_s_tready)
                advance_parser(cur_item);
            if (i_cfg_valid && o_cfg_ready)
                node_cnt = i_cfg_data;
            if (i_s_tvalid || reply_q.size() != 0)
                settle = 0;
            else if (settle < SETTLE_CYC)
                settle++;
            nv_s = s_busy;
            nv_c = c_busy;
            if (!s_busy && !c_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() != 0) begin
                    it = pending_q[0];
                    case (it.kind)
                        ENT_ITEM: begin
                            if (!quiet_tail && !calm && $urandom_range(0, 5) == 0) begin
                                gap_left = $urandom_range(0, 2);
                            end else begin
                                cur_item = it;
                                void'(pending_q.pop_front());
                                nv_s = 1'b1;
                                i_s_tdata <= {6'b0, it.mask, it.ar, it.wd, it.ch};
                                i_s_tuser <= it.op;
                            end
                        end
                        ENT_CFG: begin
                            if (settle >= SETTLE_CYC) begin
                                nv_c = 1'b1;
                                i_cfg_data <= it.cfg;
                                void'(pending_q.pop_front());
                            end
                        end
                        default: begin
                            if (settle >= SETTLE_CYC)
                                void'(pending_q.pop_front());
                        end
                    endcase
                end
            end
            i_s_tvalid  <= nv_s;
            i_cfg_valid <= nv_c;
        end
    end

    // receiver: random stalls and reply checking
    always @(posedge i_clk) begin
        t_exp e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (reply_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected reply item %h", o_m_tdata);
                end else begin
                    e = reply_q.pop_front();
                    if (o_m_tdata[1:0] !== e.code || o_m_tdata[2] !== e.req ||
                        o_m_tdata[5:3] !== e.node) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %s/%0d/%0d got %0d/%0d/%0d",
                                     e.code.name(), e.req, e.node,
                                     o_m_tdata[1:0], o_m_tdata[2], o_m_tdata[5:3]);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!quiet_tail && !calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [3:0] counts[7];
        int target;
        counts = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd5, 4'd8};
        node_cnt = uclp_pkg::KNOWN_NODES_RST;
        act_node = 3'd0;
        clear_line();

        // directed lines at the reset node count
        dir_on = 1'b1;
        dir_wd = 1'b0;
        dir_ar = 1'b1;
        dir_mask = 8'h00;
        push_item(1'b0, uclp_pkg::CHAR_CR);         // empty line
        push_text("CMD:PING");
        dir_wd = 1'b1;
        dir_ar = 1'b0;
        dir_mask = 8'hFF;
        push_item(1'b0, uclp_pkg::CHAR_LF);         // ping ignores busy inputs
        dir_wd = 1'b0;
        dir_ar = 1'b1;
        dir_mask = 8'h00;
        push_text("CM");
        push_item(1'b1, 8'hFF);                     // receive error drops partial line
        push_item(1'b0, uclp_pkg::CHAR_CR);
        push_item(1'b0, 8'h00);                     // NUL is an ordinary character
        push_item(1'b0, 8'hFF);
        push_item(1'b0, uclp_pkg::CHAR_CR);
        push_text("CMD:MEASURE");
        dir_mask = 8'hFE;
        push_item(1'b0, uclp_pkg::CHAR_CR);
        dir_on = 1'b0;

        foreach (counts[p]) begin
            push_ctrl(ENT_CFG, counts[p]);
            target = stim_items + ITEMS_PHASE;
            while (stim_items < target) begin
                add_random_line();
                if (stim_items >= target - ITEMS_PHASE / 2 &&
                    stim_items < target - ITEMS_PHASE / 2 + 16)
                    push_ctrl(ENT_DRAIN, 4'd0);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_q.size() != 0 || i_s_tvalid || i_cfg_valid);
        for (int k = 0; k < 2000 && reply_q.size() != 0; k++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        leftover = reply_q.size();
        if (leftover != 0)
            $display("%0d expected replies never arrived", leftover);
        if (mismatches == 0 && leftover == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
